// ===== src/dwc3_pkg.sv =====
// Shared types and constants of the streaming 3x3 depthwise convolution.
package dwc3_pkg;

  localparam int DATA_W   = 16;
  localparam int ACC_W    = 36;
  localparam int POS_W    = 8;
  localparam int DIM_W    = 9;
  localparam int CIDX_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int TAPS     = 9;
  localparam int COEFS    = 10;
  localparam int FRAC_W   = 8;
  localparam int WIN      = 3;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [CIDX_W-1:0] BIAS_IDX = CIDX_W'(9);

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_VALUE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_MAX      = 3'd4;

  typedef struct packed {
    logic                     opcode;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     last_of_run;
  } out_item_t;

  // One output pixel in flight: remaining taps, position and partial sum.
  typedef struct packed {
    logic [TAPS-1:0][DATA_W-1:0] taps;
    logic [POS_W-1:0]            row;
    logic [POS_W-1:0]            col;
    logic                        last;
    logic signed [ACC_W-1:0]     acc;
  } job_t;

endpackage

// ===== src/dwc3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dwc3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dwc3_cell.sv =====
// One multiply-accumulate cell of the tap chain.
module dwc3_cell
  import dwc3_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  job_t                     job_i,
  input  logic signed [DATA_W-1:0] coef_i,
  output logic                     valid_o,
  output job_t                     job_o
);

  logic signed [2*DATA_W-1:0] prod;
  job_t                       job_d;
  job_t                       job_q;
  logic                       valid_q;

  // Consume the lowest tap, hand the rest down.
  always_comb begin
    prod      = $signed(job_i.taps[0]) * coef_i;
    job_d     = job_i;
    job_d.taps = job_i.taps >> DATA_W;
    job_d.acc = job_i.acc + ACC_W'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      job_q <= job_d;
    end
  end

  assign valid_o = valid_q;
  assign job_o   = job_q;

endmodule

// ===== src/dwc3_front.sv =====
// Pixel counters, line store, 3x3 window, coefficients and job generation.
module dwc3_front
  import dwc3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  in_item_t                           in_data_i,
  output logic                               in_stall_o,
  input  logic                               adv_i,
  input  logic                               chain_busy_i,
  input  logic [DIM_W-1:0]                   frame_width_i,
  input  logic [DIM_W-1:0]                   frame_height_i,
  input  logic signed [DATA_W-1:0]           pad_i,
  input  logic                               geo_rst_i,
  output logic                               job_valid_o,
  output job_t                               job_o,
  output logic [TAPS-1:0][DATA_W-1:0]        coef_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_q, col_d, w_last;
  logic [RW-1:0] row_q, row_d, h_last;
  logic [CW-1:0] pj_q;
  logic [RW-1:0] pi_q;
  logic [3:0]    mask_q, mask_d, mask_new, low, rest;
  logic signed [DATA_W-1:0] coef_q [COEFS];
  logic [DATA_W-1:0] win_q [WIN][WIN];
  logic [2*DATA_W-1:0] rdata, wdata;
  logic gen_free, pix_acc, coef_acc;
  logic ro, co;
  logic [RW-1:0] cr;
  logic [CW-1:0] cc;

  always_comb begin
    if (frame_width_i < DIM_W'(2)) begin
      w_last = CW'(1);
    end else if (int'(frame_width_i) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(frame_width_i - DIM_W'(1));
    end
    if (frame_height_i < DIM_W'(2)) begin
      h_last = RW'(1);
    end else if (int'(frame_height_i) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(frame_height_i - DIM_W'(1));
    end
  end

  assign gen_free = (mask_q == 4'd0) || (adv_i && ((mask_q & (mask_q - 4'd1)) == 4'd0));
  assign in_stall_o = (in_data_i.opcode == OP_PIXEL) ? !gen_free
                                                     : ((mask_q != 4'd0) || chain_busy_i);
  assign pix_acc  = in_valid_i && !in_stall_o && (in_data_i.opcode == OP_PIXEL);
  assign coef_acc = in_valid_i && !in_stall_o && (in_data_i.opcode == OP_COEF);

  // Advance the raster position.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (geo_rst_i) begin
      col_d = '0;
      row_d = '0;
    end else if (pix_acc) begin
      if (col_q == w_last) begin
        col_d = '0;
        row_d = (row_q == h_last) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_comb begin
    mask_new[0] = (row_q != '0) && (col_q != '0);
    mask_new[1] = (row_q != '0) && (col_q == w_last);
    mask_new[2] = (row_q == h_last) && (col_q != '0);
    mask_new[3] = (row_q == h_last) && (col_q == w_last);
    low  = mask_q & (~mask_q + 4'd1);
    rest = mask_q & ~low;
    if (pix_acc) begin
      mask_d = mask_new;
    end else if (adv_i) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      mask_q <= '0;
      for (int k = 0; k < COEFS; k++) begin
        coef_q[k] <= '0;
      end
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      mask_q <= mask_d;
      if (coef_acc && (in_data_i.coef_index <= BIAS_IDX)) begin
        coef_q[in_data_i.coef_index] <= in_data_i.data_value;
      end
    end
  end

  // Line store entry holds {row above, two rows above} for each column.
  assign wdata = {in_data_i.data_value, rdata[2*DATA_W-1:DATA_W]};

  dwc3_ram #(
    .WIDTH (2*DATA_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (pix_acc),
    .waddr_i (col_q),
    .wdata_i (wdata),
    .raddr_i (col_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      pi_q <= row_q;
      pj_q <= col_q;
      for (int r = 0; r < WIN; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rdata[DATA_W-1:0];
      win_q[1][2] <= rdata[2*DATA_W-1:DATA_W];
      win_q[2][2] <= in_data_i.data_value;
    end
  end

  // Build the job for the lowest pending output.
  always_comb begin
    ro = low[2] || low[3];
    co = low[1] || low[3];
    cr = ro ? pi_q : pi_q - RW'(1);
    cc = co ? pj_q : pj_q - CW'(1);
    job_o.row  = POS_W'(cr);
    job_o.col  = POS_W'(cc);
    job_o.last = (rest == 4'd0);
    job_o.acc  = ACC_W'(coef_q[COEFS-1]) <<< FRAC_W;
    for (int a = 0; a < WIN; a++) begin
      for (int b = 0; b < WIN; b++) begin
        job_o.taps[a*WIN+b] = pad_i;
        if (!((a == 0) && (cr == '0)) && !((b == 0) && (cc == '0))) begin
          if (ro && co) begin
            if ((a < WIN-1) && (b < WIN-1)) job_o.taps[a*WIN+b] = win_q[a+1][b+1];
          end else if (ro) begin
            if (a < WIN-1) job_o.taps[a*WIN+b] = win_q[a+1][b];
          end else if (co) begin
            if (b < WIN-1) job_o.taps[a*WIN+b] = win_q[a][b+1];
          end else begin
            job_o.taps[a*WIN+b] = win_q[a][b];
          end
        end
      end
    end
  end

  assign job_valid_o = (mask_q != 4'd0);

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      coef_o[k] = coef_q[k];
    end
  end

endmodule

// ===== src/depthwise_conv3x3_stream_unit.sv =====
// Latency: a pixel's first result appears after the window and mask registers, the nine cells
// and the output register. Throughput: one pixel per cycle while the output is not stalled; a
// pixel that yields more than one result holds the next input while the job generator issues
// one result into the tap chain per cycle. Coefficient loads wait until the chain drains. Reset
// clears counters, coefficients and valid flags and loads configuration defaults; no clearing pass.
module depthwise_conv3x3_stream_unit
  import dwc3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  in_item_t             in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output out_item_t            out_data_o,
  input  logic                 out_stall_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  logic [DIM_W-1:0]         fw_q, fh_q;
  logic signed [DATA_W-1:0] pad_q, amin_q, amax_q;
  logic                     cfg_we, geo_rst, adv;
  logic [TAPS:0]            cv;
  job_t                     cj [TAPS+1];
  logic [TAPS-1:0][DATA_W-1:0] coef;
  logic signed [ACC_W-FRAC_W-1:0] q, lo, hi, qc;
  logic                     out_valid_q;
  out_item_t                out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we  = cfg_valid_i && cfg_ready_o;
  assign geo_rst = cfg_we && ((cfg_index_i == CFG_FRAME_WIDTH) ||
                              (cfg_index_i == CFG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= DIM_W'(2);
      fh_q   <= DIM_W'(2);
      pad_q  <= '0;
      amin_q <= 16'sh8000;
      amax_q <= 16'sh7fff;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  fw_q   <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: fh_q   <= cfg_data_i[DIM_W-1:0];
        CFG_PAD_VALUE:    pad_q  <= cfg_data_i;
        CFG_ACT_MIN:      amin_q <= cfg_data_i;
        CFG_ACT_MAX:      amax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole chain moves together whenever the output register can take a result.
  assign adv = !out_valid_q || !out_stall_i;

  dwc3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_data_i      (in_data_i),
    .in_stall_o     (in_stall_o),
    .adv_i          (adv),
    .chain_busy_i   (|cv[TAPS:1]),
    .frame_width_i  (fw_q),
    .frame_height_i (fh_q),
    .pad_i          (pad_q),
    .geo_rst_i      (geo_rst),
    .job_valid_o    (cv[0]),
    .job_o          (cj[0]),
    .coef_o         (coef)
  );

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    dwc3_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (cv[k]),
      .job_i   (cj[k]),
      .coef_i  (coef[k]),
      .valid_o (cv[k+1]),
      .job_o   (cj[k+1])
    );
  end

  // Floor shift, then clamp low before high.
  always_comb begin
    q  = cj[TAPS].acc[ACC_W-1:FRAC_W];
    lo = (ACC_W-FRAC_W)'(amin_q);
    hi = (ACC_W-FRAC_W)'(amax_q);
    qc = q;
    if (qc < lo) qc = lo;
    if (qc > hi) qc = hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cv[TAPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_row     <= cj[TAPS].row;
      out_q.out_col     <= cj[TAPS].col;
      out_q.out_value   <= qc[DATA_W-1:0];
      out_q.last_of_run <= cj[TAPS].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
